// ===== hdl/pss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and fixed constants of the plucked-string voice.
// ----------------------------------------------------------------------------
package pss_pkg;

   localparam int CMD_BITS    = 2;
   localparam int FREQ_BITS   = 20;
   localparam int SR_BITS     = 17;
   localparam int FRAC_BITS   = 16;
   localparam int WEIGHT_BITS = FRAC_BITS + 1;

   // quotient of (fs_hz << FREQ_BITS) / freq
   localparam int QUO_BITS    = SR_BITS + FREQ_BITS;
   localparam int DIV_CNT_BITS = $clog2(QUO_BITS + 1);

   localparam logic [SR_BITS-1:0] SR_RESET = SR_BITS'(48000);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PLUCK = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ_B,
      ST_MULT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic start;
      logic [SR_BITS-1:0] fs_hz;
      logic [FREQ_BITS-1:0] freq;
   } div_req_type;

endpackage
`default_nettype wire

// ===== hdl/plucked_string_synth_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plucked_string_synth_top
// Karplus-Strong string voice with a linearly interpolated fractional delay
// held in a single delay-line memory.
// ----------------------------------------------------------------------------
//  channel | direction | ports              | content
//  req     | in        | req_t*             | pluck, load or tick word
//  rsp     | out       | rsp_t*             | one sample word per tick
//  csr     | in        | csr_valid/ready    | sample rate
//
//  load: written as it is taken. tick: read a, read b, multiply, write back,
//  in steps set by the single read port of the delay line. pluck: runs
//  the one-bit-per-cycle divider over a 37-bit quotient.
//  synchronous reset clears control state; the delay line is not cleared.
//  a tick waits in its write-back cycle while a previous sample is untaken.
module plucked_string_synth_top #(
   parameter int MAX_DELAY   = 2048,
   parameter int SAMPLE_BITS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // [19:0] freq_q4, [SAMPLE_BITS+19:20] noise_sample, zero padding above
   input  wire  [((pss_pkg::FREQ_BITS+SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // [1:0] cmd
   input  wire  [pss_pkg::CMD_BITS-1:0]          req_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // [SAMPLE_BITS-1:0] sample, zero padding above
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]      rsp_tdata,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [pss_pkg::SR_BITS-1:0]           csr_data
);

   localparam int AW = $clog2(MAX_DELAY);
   localparam int LW = AW + 1;
   localparam int SB = SAMPLE_BITS;
   localparam int WB = pss_pkg::WEIGHT_BITS;
   localparam int PW = SB + 1 + WB + 1;
   localparam int RSP_W = ((SB + 7) / 8) * 8;

   pss_pkg::state_type state_ff, state_in;
   pss_pkg::cmd_type   cmd;
   pss_pkg::div_req_type div_req;

   logic [pss_pkg::SR_BITS-1:0] fs_hz_ff;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [LW-1:0]       length_ff, length_in;
   logic [WB-1:0]       weight_ff, weight_in;
   logic [SB-1:0]       prev_ff, prev_in;
   logic [LW-1:0]       fill_ff, fill_in;
   logic signed [SB-1:0] a_ff, a_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]       rsp_data_ff, rsp_data_in;

   logic                div_done;
   logic [LW-1:0]       div_length;
   logic [WB-1:0]       div_weight;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [SB-1:0]       wr_data;
   logic [AW-1:0]       rd_addr;
   logic signed [SB-1:0] rd_data;

   logic [LW-1:0]       pos_plus;
   logic [AW-1:0]       nxt;
   logic signed [SB:0]  diff;
   logic signed [PW-1:0] rounded;
   logic signed [SB+2:0] out_wide;
   logic signed [SB-1:0] out_sample;
   logic signed [SB:0]  avg_sum;
   logic                req_fire;
   logic                rsp_free;

   assign cmd      = pss_pkg::cmd_type'(req_tuser);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign pos_plus = {1'b0, pos_ff} + LW'(1);
   assign nxt      = (pos_plus == length_ff) ? '0 : pos_plus[AW-1:0];

   // (b - a) * w, then a + round((b - a) * w / 2^16)
   assign diff       = SB'(rd_data) - a_ff;
   assign rounded    = prod_ff + (PW'(1) <<< (pss_pkg::FRAC_BITS - 1));
   assign out_wide   = (SB+3)'(a_ff) + rounded[PW-1:pss_pkg::FRAC_BITS];
   assign out_sample = out_wide[SB-1:0];
   assign avg_sum    = (SB+1)'($signed(prev_ff)) + (SB+1)'(out_sample);

   assign div_req.start = req_fire && (cmd == pss_pkg::CMD_PLUCK);
   assign div_req.fs_hz = fs_hz_ff;
   assign div_req.freq  = req_tdata[pss_pkg::FREQ_BITS-1:0];

   pss_divider #(
      .MAX_DELAY (MAX_DELAY)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .done    (div_done),
      .length  (div_length),
      .weight  (div_weight)
   );

   pss_delay_ram #(
      .DEPTH (MAX_DELAY),
      .WIDTH (SB)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      length_in    = length_ff;
      weight_in    = weight_ff;
      prev_in      = prev_ff;
      fill_in      = fill_ff;
      a_in         = a_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = avg_sum[SB:1];
      rd_addr      = pos_ff;
      case (state_ff)
         pss_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            // entry a is read here so it is ready once a tick is taken
            if (req_fire) begin
               case (cmd)
                  pss_pkg::CMD_PLUCK: begin
                     pos_in   = '0;
                     fill_in  = '0;
                     prev_in  = '0;
                     state_in = pss_pkg::ST_DIVIDE;
                  end
                  pss_pkg::CMD_LOAD: begin
                     if (fill_ff < length_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = fill_ff[AW-1:0];
                        wr_data = req_tdata[pss_pkg::FREQ_BITS +: SB];
                        fill_in = fill_ff + LW'(1);
                     end
                  end
                  pss_pkg::CMD_TICK: begin
                     state_in = pss_pkg::ST_READ_B;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pss_pkg::ST_DIVIDE: begin
            if (div_done) begin
               length_in = div_length;
               weight_in = div_weight;
               state_in  = pss_pkg::ST_IDLE;
            end
         end
         pss_pkg::ST_READ_B: begin
            a_in     = rd_data;
            rd_addr  = nxt;
            state_in = pss_pkg::ST_MULT;
         end
         pss_pkg::ST_MULT: begin
            prod_in  = PW'(diff) * PW'($signed({1'b0, weight_ff}));
            state_in = pss_pkg::ST_WRITE;
         end
         pss_pkg::ST_WRITE: begin
            if (rsp_free) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = out_sample;
               prev_in      = out_sample;
               pos_in       = nxt;
               state_in     = pss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pss_pkg::ST_IDLE;
         fs_hz_ff       <= pss_pkg::SR_RESET;
         pos_ff         <= '0;
         length_ff      <= LW'(1);
         weight_ff      <= '0;
         prev_ff        <= '0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         length_ff    <= length_in;
         weight_ff    <= weight_in;
         prev_ff      <= prev_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            fs_hz_ff <= csr_data;
         end
      end
      a_ff        <= a_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule
`default_nettype wire

// ===== hdl/pss_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pss_divider
// Bit-serial restoring divider turning sample rate and frequency into the
// clamped loop length and fractional weight.
// ----------------------------------------------------------------------------
module pss_divider #(
   parameter int MAX_DELAY = 2048
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire  pss_pkg::div_req_type            div_req,
   output logic                                  done,
   output logic [$clog2(MAX_DELAY):0]            length,
   output logic [pss_pkg::WEIGHT_BITS-1:0]       weight
);

   localparam int AW = $clog2(MAX_DELAY);
   localparam int LW = AW + 1;
   localparam int QB = pss_pkg::QUO_BITS;
   localparam int FB = pss_pkg::FREQ_BITS;
   localparam int CB = pss_pkg::DIV_CNT_BITS;
   localparam logic [QB-1:0] LIMIT = QB'(MAX_DELAY - 1) << pss_pkg::FRAC_BITS;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CB-1:0]   cnt_ff, cnt_in;
   logic [FB-1:0]   rem_ff, rem_in;
   logic [FB-1:0]   dvs_ff, dvs_in;
   logic [QB-1:0]   dvd_ff, dvd_in;
   logic [QB-1:0]   quo_ff, quo_in;
   logic [FB:0]     trial;
   logic [FB:0]     diff;
   logic [QB-1:0]   quo_clamp;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, dvd_ff[QB-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = div_req.freq;
         dvd_in  = {div_req.fs_hz, {FB{1'b0}}};
         quo_in  = '0;
      end else if (busy_ff) begin
         // zero divisor always subtracts, so the quotient saturates and clamps
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[FB-1:0];
            quo_in = {quo_ff[QB-2:0], 1'b1};
         end else begin
            rem_in = trial[FB-1:0];
            quo_in = {quo_ff[QB-2:0], 1'b0};
         end
         dvd_in = {dvd_ff[QB-2:0], 1'b0};
         cnt_in = cnt_ff + CB'(1);
         if (cnt_ff == CB'(QB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign quo_clamp = (quo_ff > LIMIT) ? LIMIT : quo_ff;
   assign done      = done_ff;
   assign length    = {1'b0, quo_clamp[pss_pkg::FRAC_BITS +: AW]} + LW'(1);
   assign weight    = (pss_pkg::WEIGHT_BITS'(1) << pss_pkg::FRAC_BITS)
                      - {1'b0, quo_clamp[pss_pkg::FRAC_BITS-1:0]};

endmodule
`default_nettype wire

// ===== hdl/pss_delay_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pss_delay_ram
// Delay-line memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pss_delay_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 16
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire  [WIDTH-1:0]          wr_data,
   input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives plucked_string_synth_top with pluck, load and tick words over a
// range of sample-rate settings. A predictor of the string voice tracks the
// delay line and works out every sample; the sample stream is checked word
// by word against it. A short hand-written sequence comes first and covers
// the field extremes, ignored words and the clamped-delay cases. It is
// followed by randomised pluck-load-tick runs with noise words mixed in.
// ----------------------------------------------------------------------------
module testbench;

   typedef longint unsigned u64_type;

   localparam int CMD_BITS     = pss_pkg::CMD_BITS;
   localparam int FREQ_BITS    = pss_pkg::FREQ_BITS;
   localparam int SR_BITS      = pss_pkg::SR_BITS;
   localparam int FRAC_BITS    = pss_pkg::FRAC_BITS;
   localparam logic [SR_BITS-1:0] SR_RESET = pss_pkg::SR_RESET;
   localparam logic [CMD_BITS-1:0] CMD_PLUCK = pss_pkg::CMD_PLUCK;
   localparam logic [CMD_BITS-1:0] CMD_LOAD  = pss_pkg::CMD_LOAD;
   localparam logic [CMD_BITS-1:0] CMD_TICK  = pss_pkg::CMD_TICK;

   localparam int MAX_DELAY    = 2048;
   localparam int SAMPLE_BITS  = 16;
   localparam int DATA_W       = ((FREQ_BITS + SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_W        = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_CYCLES  = 60;     // longer than a pluck's divide
   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_WORDS = 600;
   localparam int PHASES       = 7;
   localparam int MAX_REPORTS  = 10;
   localparam longint WEIGHT_ONE = 65536;

   typedef struct {
      logic [CMD_BITS-1:0]          cmd;
      logic [FREQ_BITS-1:0]         freq;
      logic signed [SAMPLE_BITS-1:0] noise;
      bit                           known;
      logic signed [SAMPLE_BITS-1:0] want;
   } stim_row_type;

   bit clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic [CMD_BITS-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [SR_BITS-1:0] csr_data = '0;

   // predictor state
   logic signed [SAMPLE_BITS-1:0] line_mem [MAX_DELAY];
   bit line_written [MAX_DELAY];
   int unsigned rd_pos = 0;
   int unsigned loop_len = 1;
   int unsigned fill_pos = 0;
   longint weight = 0;
   logic signed [SAMPLE_BITS-1:0] last_out = '0;
   logic [SR_BITS-1:0] rate_hz = SR_RESET;

   logic signed [SAMPLE_BITS-1:0] pending_samples [$];

   int unsigned error_count = 0;
   int unsigned word_count = 0;
   int unsigned pluck_count = 0;
   int unsigned load_count = 0;
   int unsigned tick_count = 0;
   int unsigned sample_count = 0;
   int unsigned burst_left = 0;
   int unsigned ready_mode = 0;
   int unsigned ready_left = 0;
   int unsigned stall_cycles = 0;

   stim_row_type directed_words [26] = '{
      '{CMD_UNUSED, 20'd5,      16'sd7,      1'b0, 16'sd0},
      '{CMD_PLUCK,  20'd768000, 16'sd0,      1'b0, 16'sd0},   // length 2, weight one
      '{CMD_LOAD,   20'd0,      16'sh7FFF,   1'b0, 16'sd0},
      '{CMD_LOAD,   20'd0,      16'sh8000,   1'b0, 16'sd0},
      '{CMD_LOAD,   20'd0,      16'sd1000,   1'b0, 16'sd0},   // past the loop, dropped
      '{CMD_TICK,   20'd0,      16'sd0,      1'b1, 16'sh8000},
      '{CMD_TICK,   20'd0,      16'sd0,      1'b1, 16'shC000},
      '{CMD_TICK,   20'd0,      16'sd0,      1'b1, 16'shA000},
      '{CMD_PLUCK,  20'd0,      16'sd0,      1'b0, 16'sd0},   // zero frequency clamps
      '{CMD_LOAD,   20'hFFFFF,  16'sh1234,   1'b0, 16'sd0},
      '{CMD_LOAD,   20'd0,      16'shFFFF,   1'b0, 16'sd0},
      '{CMD_TICK,   20'd0,      16'sd0,      1'b1, 16'shFFFF},
      '{CMD_PLUCK,  20'hFFFFF,  16'shFFFF,   1'b0, 16'sd0},   // single-entry loop
      '{CMD_LOAD,   20'd0,      16'sd100,    1'b0, 16'sd0},
      '{CMD_TICK,   20'd0,      16'sd0,      1'b1, 16'sd100},
      '{CMD_TICK,   20'd0,      16'sd0,      1'b1, 16'sd50},
      '{CMD_PLUCK,  20'd480,    16'sd0,      1'b0, 16'sd0},   // lowest string
      '{CMD_LOAD,   20'd0,      16'sh8000,   1'b0, 16'sd0},
      '{CMD_TICK,   20'd0,      16'sd0,      1'b0, 16'sd0},
      '{CMD_PLUCK,  20'd307200, 16'sd0,      1'b0, 16'sd0},   // half-sample delay
      '{CMD_LOAD,   20'd0,      16'sd10,     1'b0, 16'sd0},
      '{CMD_LOAD,   20'd0,      16'sd21,     1'b0, 16'sd0},
      '{CMD_TICK,   20'd0,      16'sd0,      1'b0, 16'sd0},   // line only partly loaded
      '{CMD_LOAD,   20'd0,      -16'sd7,     1'b0, 16'sd0},
      '{CMD_TICK,   20'd0,      16'sd0,      1'b0, 16'sd0},
      '{CMD_TICK,   20'd0,      16'sd0,      1'b0, 16'sd0}
   };

   plucked_string_synth_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one string voice step; returns 1 when the word yields a sample
   function automatic bit voice_step(input logic [CMD_BITS-1:0] cmd,
                                     input logic [FREQ_BITS-1:0] freq,
                                     input logic signed [SAMPLE_BITS-1:0] noise,
                                     output logic signed [SAMPLE_BITS-1:0] sample);
      u64_type quo;
      u64_type cap;
      int unsigned nxt;
      longint a;
      longint b;
      longint acc;
      sample = '0;
      case (cmd)
         CMD_PLUCK: begin
            cap = u64_type'(MAX_DELAY - 1) << FRAC_BITS;
            quo = (freq == 0) ? cap : (u64_type'(rate_hz) << FREQ_BITS) / u64_type'(freq);
            if (quo > cap) quo = cap;
            loop_len = int'(quo >> FRAC_BITS) + 1;
            weight = WEIGHT_ONE - longint'(quo & 64'hFFFF);
            rd_pos = 0;
            fill_pos = 0;
            last_out = '0;
            return 1'b0;
         end
         CMD_LOAD: begin
            if (fill_pos < loop_len && fill_pos < MAX_DELAY) begin
               line_mem[fill_pos] = noise;
               line_written[fill_pos] = 1'b1;
               fill_pos++;
            end
            return 1'b0;
         end
         CMD_TICK: begin
            nxt = (rd_pos + 1) % loop_len;
            a = longint'(line_mem[rd_pos]);
            b = longint'(line_mem[nxt]);
            acc = a * (WEIGHT_ONE - weight) + b * weight + 32768;
            sample = SAMPLE_BITS'(acc >>> 16);
            line_mem[rd_pos] = SAMPLE_BITS'((longint'(last_out) + longint'(sample)) >>> 1);
            last_out = sample;
            rd_pos = nxt;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // both taps of the next tick must hold written data
   function automatic bit tick_ready();
      return line_written[rd_pos] && line_written[(rd_pos + 1) % loop_len];
   endfunction

   task automatic flag_error(input string what, input logic [RSP_W-1:0] want,
                             input logic [RSP_W-1:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("error: %s, expected %0d got %0d", what, $signed(want), $signed(got));
   endtask

   // entered and left just after a falling edge
   task automatic send_word(input logic [CMD_BITS-1:0] cmd, input logic [FREQ_BITS-1:0] freq,
                            input logic signed [SAMPLE_BITS-1:0] noise, input bit known,
                            input logic signed [SAMPLE_BITS-1:0] want);
      logic signed [SAMPLE_BITS-1:0] predicted;
      int unsigned gap;
      bit counted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {{(DATA_W - FREQ_BITS - SAMPLE_BITS){1'b0}}, noise, freq};
      do @(posedge clock); while (!req_tready);
      counted = (cmd != CMD_UNUSED) && !(cmd == CMD_LOAD && fill_pos >= loop_len);
      case (cmd)
         CMD_PLUCK: pluck_count++;
         CMD_LOAD:  load_count += counted;
         CMD_TICK:  tick_count++;
         default: ;
      endcase
      word_count += counted;
      if (voice_step(cmd, freq, noise, predicted))
         pending_samples.push_back(known ? want : predicted);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_noise();
      logic [FREQ_BITS-1:0] f;
      logic signed [SAMPLE_BITS-1:0] n;
      f = FREQ_BITS'($urandom);
      n = SAMPLE_BITS'($urandom);
      case ($urandom_range(0, 3))
         0: send_word(CMD_UNUSED, f, n, 1'b0, '0);
         1: send_word(CMD_PLUCK, ($urandom_range(0, 3) == 0) ?
                      FREQ_BITS'($urandom_range(0, 2000)) : f, n, 1'b0, '0);
         2: send_word(CMD_LOAD, f, n, 1'b0, '0);
         default: begin
            if (tick_ready())
               send_word(CMD_TICK, f, n, 1'b0, '0);
            else
               send_word(CMD_LOAD, f, n, 1'b0, '0);
         end
      endcase
   endtask

   // receiver stall pattern, redrawn whenever its run ends
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(10, 80);
      end
      ready_left--;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (ready_left % 16) < 12;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            flag_error("sample word with none pending", 'x, rsp_tdata);
         end else begin
            if (rsp_tdata[SAMPLE_BITS-1:0] !== pending_samples[0])
               flag_error("sample mismatch", pending_samples[0], rsp_tdata);
            void'(pending_samples.pop_front());
            sample_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("FAIL plucked_string_synth_top");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [SR_BITS-1:0] rate_plan [PHASES];
      logic [FREQ_BITS-1:0] freq;
      u64_type dq;
      u64_type quo;
      int unsigned start_count;
      int unsigned len_goal;
      int unsigned loads;
      int unsigned ticks;
      int unsigned pick;
      int unsigned drain;

      rate_plan = '{17'd8000, 17'd96000, 17'd0, 17'h1FFFF, 17'd0, 17'd0, 17'd48000};
      rate_plan[4] = SR_BITS'($urandom_range(8000, 96000));
      rate_plan[5] = SR_BITS'($urandom);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_words[i])
         send_word(directed_words[i].cmd, directed_words[i].freq, directed_words[i].noise,
                   directed_words[i].known, directed_words[i].want);

      for (int p = 0; p < PHASES; p++) begin
         // sample rate only changes once the voice has gone quiet
         req_tvalid <= 1'b0;
         @(negedge clock);
         while (pending_samples.size() != 0) @(negedge clock);
         repeat (IDLE_CYCLES) @(negedge clock);
         csr_valid <= 1'b1;
         csr_data <= rate_plan[p];
         do @(posedge clock); while (!csr_ready);
         rate_hz = rate_plan[p];
         @(negedge clock);
         csr_valid <= 1'b0;

         start_count = word_count;
         while (word_count - start_count < RANDOM_WORDS / PHASES) begin
            if ($urandom_range(0, 9) == 0) begin
               send_noise();
               continue;
            end
            // mostly short loops so the line can be filled cheaply
            pick = $urandom_range(0, 19);
            len_goal = (pick < 16) ? $urandom_range(1, 12) :
                       (pick < 19) ? $urandom_range(13, 100) : $urandom_range(101, 600);
            dq = (u64_type'(len_goal - 1) << FRAC_BITS) | u64_type'($urandom_range(0, 65535));
            if (dq == 0) dq = 1;
            quo = (u64_type'(rate_hz) << FREQ_BITS) / dq;
            if (quo == 0)
               freq = FREQ_BITS'($urandom_range(1, 20'hFFFFF));
            else
               freq = (quo > 20'hFFFFF) ? 20'hFFFFF : FREQ_BITS'(quo);
            send_word(CMD_PLUCK, freq, SAMPLE_BITS'($urandom), 1'b0, '0);

            loads = ((loop_len < 48) ? loop_len : 48) + $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0) loads = $urandom_range(0, loads);
            for (int k = 0; k < loads; k++) begin
               if ($urandom_range(0, 19) == 0)
                  send_noise();
               else
                  send_word(CMD_LOAD, FREQ_BITS'($urandom), SAMPLE_BITS'($urandom), 1'b0, '0);
            end

            ticks = $urandom_range(1, 40);
            for (int k = 0; k < ticks; k++) begin
               if (!tick_ready()) break;
               send_word(CMD_TICK, FREQ_BITS'($urandom), SAMPLE_BITS'($urandom), 1'b0, '0);
            end
         end
      end

      req_tvalid <= 1'b0;
      drain = 0;
      while (pending_samples.size() != 0 && drain < STALL_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (IDLE_CYCLES) @(negedge clock);
      if (pending_samples.size() != 0) begin
         error_count++;
         $display("error: %0d samples never returned", pending_samples.size());
      end

      $display("covered %0d plucks, %0d loads, %0d ticks over %0d sample-rate settings",
               pluck_count, load_count, tick_count, PHASES + 1);
      $display("%0d samples checked, %0d errors", sample_count, error_count);
      if (error_count == 0)
         $display("PASS plucked_string_synth_top");
      else
         $display("FAIL plucked_string_synth_top");
      $finish;
   end

endmodule
